### src/tsnb_pkg.sv
// Shared types and constants for the texture sampler.
package tsnb_pkg;

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_NEAREST  = 2'd1,
    OP_BILINEAR = 2'd2,
    OP_NONE     = 2'd3
  } opcode_t;

  localparam int unsigned RegWidth  = 0;
  localparam int unsigned RegHeight = 1;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_BLEND_X,
    BK_BLEND_Y,
    BK_OUT
  } back_state_t;

  // Lerp of one 8-bit channel, weight t with frac fraction bits.
  function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                       input logic [16:0] t, input int unsigned frac);
    logic [16:0] one;
    logic [25:0] acc;
    one = 17'(1) << frac;
    acc = 26'(a) * 26'(one - t) + 26'(b) * 26'(t);
    return 8'(acc >> frac);
  endfunction

endpackage

### src/tsnb_if.sv
// Valid/ready channel interface carrying a generic payload.
interface tsnb_if #(parameter int unsigned W = 8) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/tsnb_front.sv
// Front end: accepts commands, computes texel addresses and blend weights.
module tsnb_front import tsnb_pkg::*; #(
  parameter int unsigned XB = 8,
  parameter int unsigned YB = 8,
  parameter int unsigned MAX_WIDTH = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned FRAC_BITS = 12,
  parameter int unsigned CW = 76
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [8:0]    tex_width,
  input  logic [8:0]    tex_height,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    opcode,
  input  logic [19:0]   u_coord,
  input  logic [19:0]   v_coord,
  input  logic [7:0]    write_x,
  input  logic [7:0]    write_y,
  input  logic [31:0]   write_rgba,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output logic [CW-1:0] cmd_data
);
  localparam int unsigned DB = 13;

  // Stage 1 registers the raw command; stage 2 produces the classified command.
  logic        s1_valid;
  logic [1:0]  s1_op;
  logic [19:0] s1_u, s1_v;
  logic [7:0]  s1_wx, s1_wy;
  logic [31:0] s1_rgba;
  logic [DB-1:0] w_eff, h_eff;

  always_comb begin
    w_eff = (tex_width == 9'd0) ? DB'(1) :
            (DB'(tex_width) > DB'(MAX_WIDTH)) ? DB'(MAX_WIDTH) : DB'(tex_width);
    h_eff = (tex_height == 9'd0) ? DB'(1) :
            (DB'(tex_height) > DB'(MAX_HEIGHT)) ? DB'(MAX_HEIGHT) : DB'(tex_height);
  end

  // Products for both filters, one multiplier per axis and filter.
  logic signed [33:0] pn_u, pn_v;
  logic [20:0]        cu, cv;
  logic [33:0]        pb_u, pb_v;
  logic [33:0]        mag_u, mag_v;
  logic [33:0]        q_u, q_v;
  always_comb begin
    pn_u = 34'(signed'(s1_u)) * signed'({1'b0, 33'(w_eff)});
    pn_v = 34'(signed'(s1_v)) * signed'({1'b0, 33'(h_eff)});
    mag_u = pn_u[33] ? 34'(-pn_u) : 34'(pn_u);
    mag_v = pn_v[33] ? 34'(-pn_v) : 34'(pn_v);
    q_u = mag_u >> FRAC_BITS;
    q_v = mag_v >> FRAC_BITS;
    cu = s1_u[19] ? 21'd0 : (21'(s1_u) > (21'(1) << FRAC_BITS)) ?
         (21'(1) << FRAC_BITS) : 21'(s1_u);
    cv = s1_v[19] ? 21'd0 : (21'(s1_v) > (21'(1) << FRAC_BITS)) ?
         (21'(1) << FRAC_BITS) : 21'(s1_v);
    pb_u = 34'(cu) * 34'(w_eff - DB'(1));
    pb_v = 34'(cv) * 34'(h_eff - DB'(1));
  end

  logic          ok;
  logic [XB-1:0] x0, x1;
  logic [YB-1:0] y0, y1;
  logic [16:0]   tx, ty;
  logic [33:0]   i0x, i0y;
  logic [31:0]   wdata;
  logic          emit, valid_cmd;

  always_comb begin
    ok = 1'b0;
    x0 = '0; x1 = '0; y0 = '0; y1 = '0; tx = '0; ty = '0;
    wdata = s1_rgba;
    i0x = pb_u >> FRAC_BITS;
    i0y = pb_v >> FRAC_BITS;
    valid_cmd = 1'b1;
    case (opcode_t'(s1_op))
      OP_WRITE: begin
        ok = (DB'(s1_wx) < w_eff) && (DB'(s1_wy) < h_eff);
        x0 = XB'(s1_wx);
        y0 = YB'(s1_wy);
        valid_cmd = ok;
      end
      OP_NEAREST: begin
        ok = !pn_u[33] && !pn_v[33] && (q_u < 34'(w_eff)) && (q_v < 34'(h_eff));
        // Negative products truncating to zero still address column or row zero.
        if (pn_u[33] && q_u == 34'd0 && !(pn_v[33] && q_v != 34'd0)
            && (q_v < 34'(h_eff))) ok = 1'b1;
        if (pn_v[33] && q_v == 34'd0 && !(pn_u[33] && q_u != 34'd0)
            && (q_u < 34'(w_eff))) ok = 1'b1;
        x0 = XB'(q_u);
        y0 = YB'(q_v);
      end
      OP_BILINEAR: begin
        ok = 1'b1;
        x0 = XB'(i0x);
        y0 = YB'(i0y);
        x1 = (34'(i0x) + 34'd1 < 34'(w_eff)) ? XB'(i0x + 34'd1) : XB'(w_eff - DB'(1));
        y1 = (34'(i0y) + 34'd1 < 34'(h_eff)) ? YB'(i0y + 34'd1) : YB'(h_eff - DB'(1));
        tx = 17'(pb_u[FRAC_BITS-1:0]);
        ty = 17'(pb_v[FRAC_BITS-1:0]);
      end
      default: valid_cmd = 1'b0;
    endcase
    emit = s1_valid && valid_cmd;
  end

  // Stage 2 output register.
  logic out_v;
  logic [CW-1:0] out_d;
  logic adv;
  assign adv = !out_v || cmd_ready;
  assign in_ready = !s1_valid || adv;
  assign cmd_valid = out_v;
  assign cmd_data = out_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (adv) out_v <= emit;
    end
    if (in_ready && in_valid) begin
      s1_op <= opcode; s1_u <= u_coord; s1_v <= v_coord;
      s1_wx <= write_x; s1_wy <= write_y; s1_rgba <= write_rgba;
    end
    if (adv) out_d <= CW'({s1_op, ok, x0, x1, y0, y1, tx, ty, wdata});
  end
endmodule

### src/tsnb_fifo.sv
// Two-entry queue between the front end and the back end.
module tsnb_fifo #(
  parameter int unsigned W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);
  logic [W-1:0] mem [2];
  logic         wp, rp;
  logic [1:0]   cnt;
  logic         push, pop;

  assign in_ready  = cnt != 2'd2;
  assign out_valid = cnt != 2'd0;
  assign out_data  = mem[rp];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
    if (push) mem[wp] <= in_data;
  end
endmodule

### src/tsnb_back.sv
// Back end: texel memory, four-read bilinear sequencer and output register.
module tsnb_back import tsnb_pkg::*; #(
  parameter int unsigned XB = 8,
  parameter int unsigned YB = 8,
  parameter int unsigned FRAC_BITS = 12,
  parameter int unsigned CW = 76
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  logic [CW-1:0] cmd_data,
  output logic          res_valid,
  input  logic          res_ready,
  output logic [31:0]   res_rgba
);
  localparam int unsigned AB = XB + YB;

  logic [31:0]   mem [2**AB];
  logic [1:0]    op;
  logic          ok;
  logic [XB-1:0] x0, x1;
  logic [YB-1:0] y0, y1;
  logic [16:0]   tx, ty;
  logic [31:0]   wdata;
  assign {op, ok, x0, x1, y0, y1, tx, ty, wdata} = cmd_data;

  back_state_t state, state_next;
  logic [2:0]  rcnt;          // read issue counter
  logic [1:0]  dcnt;          // data capture index
  logic        rd_pend;
  logic [31:0] rdata;
  logic [31:0] tex [4];
  logic [31:0] mix_top, mix_bot;
  logic        take, is_bil, nz;
  logic [AB-1:0] raddr;

  logic [1:0]  sop;
  logic        sok;
  logic [XB-1:0] sx0, sx1;
  logic [YB-1:0] sy0, sy1;
  logic [16:0] stx, sty;

  assign take = cmd_valid && (state == BK_IDLE);
  assign cmd_ready = (state == BK_IDLE) && (!(op == OP_NEAREST || op == OP_BILINEAR)
                     || !res_valid || res_ready) ? 1'b1 : 1'b0;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:    if (cmd_valid && cmd_ready && (op == OP_NEAREST || op == OP_BILINEAR))
                    state_next = BK_READ;
      BK_READ:    if (rcnt == 3'd5 || (!is_bil && rcnt == 3'd2)) state_next = BK_BLEND_X;
      BK_BLEND_X: state_next = BK_BLEND_Y;
      BK_BLEND_Y: state_next = BK_OUT;
      BK_OUT:     if (!res_valid || res_ready) state_next = BK_IDLE;
      default:    state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    case (rcnt[1:0])
      2'd0:    raddr = {sy0, sx0};
      2'd1:    raddr = {sy0, sx1};
      2'd2:    raddr = {sy1, sx0};
      default: raddr = {sy1, sx1};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      res_valid <= 1'b0;
      rcnt <= '0;
      rd_pend <= 1'b0;
    end else begin
      state <= state_next;
      rd_pend <= (state == BK_READ) && (rcnt < (is_bil ? 3'd4 : 3'd1));
      if (take && cmd_ready) rcnt <= '0;
      else if (state == BK_READ) rcnt <= rcnt + 3'd1;
      if (state == BK_OUT && (!res_valid || res_ready)) res_valid <= 1'b1;
      else if (res_valid && res_ready) res_valid <= 1'b0;
    end
    if (take && cmd_ready) begin
      sop <= op; sok <= ok; sx0 <= x0; sx1 <= x1; sy0 <= y0; sy1 <= y1;
      stx <= tx; sty <= ty; dcnt <= '0;
      if (op == OP_WRITE && ok) mem[{y0, x0}] <= wdata;
    end
    if (state == BK_READ) rdata <= mem[raddr];
    if (rd_pend) begin
      tex[dcnt] <= rdata;
      dcnt <= dcnt + 2'd1;
    end
    if (state == BK_BLEND_X) begin
      for (int k = 0; k < 4; k++) begin
        mix_top[8*k +: 8] <= lerp8(tex[0][8*k +: 8], tex[1][8*k +: 8], stx, FRAC_BITS);
        mix_bot[8*k +: 8] <= lerp8(tex[2][8*k +: 8], tex[3][8*k +: 8], stx, FRAC_BITS);
      end
    end
    if (state == BK_OUT && (!res_valid || res_ready)) begin
      if (is_bil) begin
        for (int k = 0; k < 4; k++)
          res_rgba[8*k +: 8] <= lerp8(mix_top[8*k +: 8], mix_bot[8*k +: 8], sty, FRAC_BITS);
      end else begin
        res_rgba <= nz ? tex[0] : 32'd0;
      end
    end
  end

  assign is_bil = (sop == OP_BILINEAR);
  assign nz = sok;
endmodule

### src/texture_sampler_nearest_bilinear_unit.sv
// Top level of the nearest and bilinear texture sampler.
//
// Commands arrive on the cmd channel (valid/ready): opcode 0 writes one texel,
// opcode 1 returns the nearest texel and opcode 2 returns a bilinear blend of
// four texels. Each sample yields one transaction on the res channel carrying
// red, green, blue and alpha; writes and opcode 3 yield none.
// The front end registers and classifies each command in two stages and hands
// it through a two-entry queue to the back end. The back end owns the
// single-port texel memory: a bilinear sample reads four texels, one per
// cycle, then blends along x and along y. The back end takes no new command
// until the current sample sits in the result register; a write is stored
// when the back end accepts it.
// Synchronous reset clears the control state and sets width and height to
// 256; texel memory content is undefined until written. When the receiver
// stalls the result register holds, the back end waits, the queue fills and
// then the command channel drops ready. Width and height are written over the
// APB port at byte addresses 0 and 4. The user must write them only while the
// block is idle; the block itself does not enforce this.
module texture_sampler_nearest_bilinear_unit import tsnb_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned FRAC_BITS  = 12
) (
  input  logic        clk,
  input  logic        rst,
  tsnb_if.sink        cmd,
  tsnb_if.source      res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned XB = $clog2(MAX_WIDTH);
  localparam int unsigned YB = $clog2(MAX_HEIGHT);
  localparam int unsigned CW = 2 + 1 + 2*XB + 2*YB + 34 + 32;

  logic [8:0] tex_width, tex_height;
  assign pready = 1'b1;

  // Register file: width at index 0, height at index 1.
  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width  <= 9'd256;
      tex_height <= 9'd256;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == 1'(RegWidth))       tex_width  <= pwdata[8:0];
      else if (paddr[2] == 1'(RegHeight)) tex_height <= pwdata[8:0];
    end
  end
  assign prdata = paddr[2] ? {23'd0, tex_height} : {23'd0, tex_width};

  logic          f_valid, f_ready, b_valid, b_ready;
  logic [CW-1:0] f_data, b_data;

  tsnb_front #(.XB(XB), .YB(YB), .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
               .FRAC_BITS(FRAC_BITS), .CW(CW)) u_front (
    .clk, .rst, .tex_width, .tex_height,
    .in_valid(cmd.valid), .in_ready(cmd.ready),
    .opcode(cmd.data[89:88]), .u_coord(cmd.data[87:68]), .v_coord(cmd.data[67:48]),
    .write_x(cmd.data[47:40]), .write_y(cmd.data[39:32]),
    .write_rgba(cmd.data[31:0]),
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd_data(f_data)
  );

  tsnb_fifo #(.W(CW)) u_fifo (
    .clk, .rst, .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
    .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
  );

  tsnb_back #(.XB(XB), .YB(YB), .FRAC_BITS(FRAC_BITS), .CW(CW)) u_back (
    .clk, .rst, .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd_data(b_data),
    .res_valid(res.valid), .res_ready(res.ready), .res_rgba(res.data)
  );

  // The result register never drops a pending transaction.
  assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid) else $error("result lost");
  // The queue never reports itself both empty and full.
  assert property (@(posedge clk) disable iff (rst)
    !(b_valid == 1'b0 && f_ready == 1'b0)) else $error("queue count broken");
endmodule
